FILE: rtl/core/assert_macros.svh
// assertion helpers for the rtl files, included by isodt_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");

// checked on every rising edge, reset included
`define CHK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

FILE: rtl/core/isodt_pkg.sv
// ----------------------------------------------------------------------------
// isodt_pkg
// Types, codes and calendar tables of the date/time string parser.
// ----------------------------------------------------------------------------
package isodt_pkg;

  localparam int MAX_CHARS_DEF = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_SHORT     = 4'd1;
  localparam logic [3:0] ERR_NONNUM    = 4'd2;
  localparam logic [3:0] ERR_MONTH     = 4'd3;
  localparam logic [3:0] ERR_DAY       = 4'd4;
  localparam logic [3:0] ERR_MIXED     = 4'd5;
  localparam logic [3:0] ERR_CALENDAR  = 4'd6;
  localparam logic [3:0] ERR_TRAILING  = 4'd7;
  localparam logic [3:0] ERR_SEPARATOR = 4'd8;
  localparam logic [3:0] ERR_HOUR      = 4'd9;
  localparam logic [3:0] ERR_MINUTE    = 4'd10;
  localparam logic [3:0] ERR_SECOND    = 4'd11;
  localparam logic [3:0] ERR_ZONE      = 4'd12;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } text_item_t;

  typedef struct packed {
    logic signed [62:0] tick_count;
    logic               parse_ok;
    logic [3:0]         error_code;
  } result_item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic       keep;
  } queue_entry_t;

  // day of a march-based year on which the month starts
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/isodt_front.sv
// ----------------------------------------------------------------------------
// isodt_front
// Takes string bytes, tracks the position and marks bytes that fit the store.
// ----------------------------------------------------------------------------
module isodt_front import isodt_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         text_valid,
  output logic         text_ready,
  input  text_item_t   text_data,
  output logic         push,
  output queue_entry_t push_data,
  input  logic         full
);
  localparam int LW = $clog2(MAX_CHARS + 1);

  logic [LW-1:0] position;
  logic          fits;

  assign fits       = position < LW'(MAX_CHARS);
  assign text_ready = !full;
  assign push       = text_valid && !full;
  assign push_data  = '{text_char: text_data.text_char, last_char: text_data.last_char,
                        keep: fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (push) begin
      if (text_data.last_char) begin
        position <= '0;
      end else if (fits) begin
        position <= position + 1'b1;
      end
    end
  end
endmodule

FILE: rtl/core/isodt_queue.sv
// ----------------------------------------------------------------------------
// isodt_queue
// Short queue between the byte front end and the parse back end.
// ----------------------------------------------------------------------------
module isodt_queue import isodt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_data,
  output logic         full,
  input  logic         pop,
  output queue_entry_t pop_data,
  output logic         empty
);
  queue_entry_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;

  assign full     = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

FILE: rtl/core/isodt_back.sv
// ----------------------------------------------------------------------------
// isodt_back
// Stores one string, walks it byte by byte, then works out the tick count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isodt_back import isodt_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  queue_entry_t pop_data,
  input  logic         empty,
  output logic         pop,
  input  logic         time_only_mode,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_data
);
  localparam int LW = $clog2(MAX_CHARS + 1);
  localparam int AW = $clog2(MAX_CHARS);
  localparam int PW = LW + 1;
  localparam int CW = LW + 4;

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_WALK    = 3'd2;
  localparam logic [2:0] S_CALC0   = 3'd3;
  localparam logic [2:0] S_CALC1   = 3'd4;
  localparam logic [2:0] S_CALC2   = 3'd5;
  localparam logic [2:0] S_CALC3   = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  localparam logic [4:0] PH_Y0   = 5'd0;
  localparam logic [4:0] PH_Y1   = 5'd1;
  localparam logic [4:0] PH_Y2   = 5'd2;
  localparam logic [4:0] PH_Y3   = 5'd3;
  localparam logic [4:0] PH_MO0S = 5'd4;
  localparam logic [4:0] PH_MO0D = 5'd5;
  localparam logic [4:0] PH_MO1  = 5'd6;
  localparam logic [4:0] PH_DA0S = 5'd7;
  localparam logic [4:0] PH_DA0D = 5'd8;
  localparam logic [4:0] PH_DA1  = 5'd9;
  localparam logic [4:0] PH_TSEP = 5'd10;
  localparam logic [4:0] PH_H0   = 5'd11;
  localparam logic [4:0] PH_H1   = 5'd12;
  localparam logic [4:0] PH_MI0S = 5'd13;
  localparam logic [4:0] PH_MI0D = 5'd14;
  localparam logic [4:0] PH_MI1  = 5'd15;
  localparam logic [4:0] PH_SE0S = 5'd16;
  localparam logic [4:0] PH_SE0D = 5'd17;
  localparam logic [4:0] PH_SE1  = 5'd18;
  localparam logic [4:0] PH_Z0   = 5'd19;
  localparam logic [4:0] PH_Z1   = 5'd20;
  localparam logic [4:0] PH_Z2   = 5'd21;
  localparam logic [4:0] PH_Z3B  = 5'd22;
  localparam logic [4:0] PH_Z4B  = 5'd23;
  localparam logic [4:0] PH_Z3E  = 5'd24;
  localparam logic [4:0] PH_Z4E  = 5'd25;
  localparam logic [4:0] PH_Z5E  = 5'd26;

  logic [2:0]          state;
  logic [4:0]          phase;
  logic [4:0]          phase_next;
  logic                stop;
  logic [3:0]          stop_err;

  logic [7:0]          store [MAX_CHARS];
  logic [LW-1:0]       length;
  logic [PW-1:0]       rd_addr;
  logic [PW-1:0]       rd_pos;
  logic [7:0]          rd_byte;
  logic                rd_vld;

  logic                mode;
  logic                date_ext;
  logic                time_ext;
  logic [3:0]          yd0, yd1, yd2, yd3;
  logic [3:0]          tens;
  logic [3:0]          month;
  logic [4:0]          day;
  logic [4:0]          hour;
  logic [5:0]          minute;
  logic [6:0]          second;
  logic [3:0]          err;

  logic [13:0]         yy;
  logic [11:0]         misc;
  logic [16:0]         secs;
  logic signed [23:0]  days;
  logic signed [40:0]  tsec;
  logic [43:0]         prod_lo;
  logic signed [44:0]  prod_hi;

  logic                result_v;
  result_item_t        result_q;
  logic                load;

  // walker view of the current byte
  logic [7:0]          cur;
  logic [7:0]          diff;
  logic [3:0]          dig;
  logic                isnum;
  logic [6:0]          pair_val;
  logic [CW-1:0]       pos_c;
  logic [CW-1:0]       len_c;
  logic [4:0]          ysum;
  logic [4:0]          csum;
  logic                yrem_zero;
  logic                leap;

  // year split for the day count
  logic [6:0]          cent;
  logic [6:0]          yrem;
  logic [6:0]          yc_n;
  logic [6:0]          yr_n;
  logic signed [62:0]  tick_sum;

  assign pop = (state == S_COLLECT) && !empty;

  assign cur      = (rd_pos < PW'(length)) ? rd_byte : 8'd0;
  assign diff     = cur - CH_ZERO;
  assign dig      = diff[3:0];
  assign isnum    = (cur >= CH_ZERO) && (cur <= CH_NINE);
  assign pair_val = 7'(tens) * 7'd10 + 7'(dig);
  assign pos_c    = CW'(rd_pos);
  assign len_c    = CW'(length);

  // leap year from the decimal digits of the year
  assign ysum      = {yd2, 1'b0} + 5'(yd3);
  assign csum      = {yd0, 1'b0} + 5'(yd1);
  assign yrem_zero = (yd2 == 4'd0) && (yd3 == 4'd0);
  assign leap      = (ysum[1:0] == 2'd0 && !yrem_zero) || (yrem_zero && csum[1:0] == 2'd0);

  always_comb begin
    stop       = 1'b0;
    stop_err   = ERR_NONE;
    phase_next = phase;
    unique case (phase)
      PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = (phase == PH_Y3) ? PH_MO0S : phase + 5'd1;
        end
      end
      PH_MO0S: begin
        if (cur == CH_DASH) begin
          phase_next = PH_MO0D;
        end else if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = PH_MO1;
        end
      end
      PH_MO0D: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = PH_MO1;
        end
      end
      PH_MO1: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else if (pair_val == 7'd0 || pair_val > 7'd12) begin
          stop = 1'b1; stop_err = ERR_MONTH;
        end else begin
          phase_next = PH_DA0S;
        end
      end
      PH_DA0S: begin
        if ((cur == CH_DASH) != date_ext) begin
          stop = 1'b1; stop_err = ERR_MIXED;
        end else if (date_ext) begin
          if (len_c < pos_c + CW'(3)) begin
            stop = 1'b1; stop_err = ERR_SHORT;
          end else begin
            phase_next = PH_DA0D;
          end
        end else if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = PH_DA1;
        end
      end
      PH_DA0D: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = PH_DA1;
        end
      end
      PH_DA1: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else if (pair_val == 7'd0 || pair_val > 7'd31) begin
          stop = 1'b1; stop_err = ERR_DAY;
        end else if (pair_val > 7'(month_length(month, leap))) begin
          stop = 1'b1; stop_err = ERR_CALENDAR;
        end else if (len_c == pos_c + CW'(1)) begin
          stop = 1'b1;
        end else if (len_c < pos_c + (date_ext ? CW'(10) : CW'(8))) begin
          stop = 1'b1; stop_err = ERR_TRAILING;
        end else begin
          phase_next = PH_TSEP;
        end
      end
      PH_TSEP: begin
        if (cur != CH_T && cur != CH_SPACE) begin
          stop = 1'b1; stop_err = ERR_SEPARATOR;
        end else if (len_c < pos_c + CW'(7)) begin
          stop = 1'b1; stop_err = ERR_SHORT;
        end else begin
          phase_next = PH_H0;
        end
      end
      PH_H0, PH_MI0D, PH_SE0D: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = phase + 5'd1;
        end
      end
      PH_H1: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else if (pair_val > 7'd23) begin
          stop = 1'b1; stop_err = ERR_HOUR;
        end else begin
          phase_next = PH_MI0S;
        end
      end
      PH_MI0S: begin
        if (cur == CH_COLON) begin
          phase_next = PH_MI0D;
        end else if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = PH_MI1;
        end
      end
      PH_MI1: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else if (pair_val > 7'd59) begin
          stop = 1'b1; stop_err = ERR_MINUTE;
        end else begin
          phase_next = PH_SE0S;
        end
      end
      PH_SE0S: begin
        if ((cur == CH_COLON) != time_ext) begin
          stop = 1'b1; stop_err = ERR_MIXED;
        end else if (time_ext) begin
          if (len_c < pos_c + CW'(3)) begin
            stop = 1'b1; stop_err = ERR_SHORT;
          end else begin
            phase_next = PH_SE0D;
          end
        end else if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else begin
          phase_next = PH_SE1;
        end
      end
      PH_SE1: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_NONNUM;
        end else if (!(hour == 5'd23 && minute == 6'd59) && pair_val > 7'd59) begin
          // seconds above 59 are let through only at 23:59, for a leap second
          stop = 1'b1; stop_err = ERR_SECOND;
        end else if (pos_c + CW'(1) < len_c) begin
          phase_next = PH_Z0;
        end else begin
          stop = 1'b1;
        end
      end
      PH_Z0: begin
        if (cur == CH_Z && len_c == pos_c + CW'(1)) begin
          stop = 1'b1;
        end else if ((cur == CH_PLUS || cur == CH_DASH) && len_c >= pos_c + CW'(3)) begin
          phase_next = PH_Z1;
        end else begin
          stop = 1'b1; stop_err = ERR_ZONE;
        end
      end
      PH_Z1, PH_Z3B, PH_Z4E: begin
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_ZONE;
        end else begin
          phase_next = phase + 5'd1;
        end
      end
      PH_Z2: begin
        // zone length picks the form: +hh, +hhmm or +hh:mm
        if (!isnum) begin
          stop = 1'b1; stop_err = ERR_ZONE;
        end else if (len_c == pos_c + CW'(1)) begin
          stop = 1'b1;
        end else if (len_c == pos_c + CW'(3)) begin
          phase_next = PH_Z3B;
        end else if (len_c == pos_c + CW'(4)) begin
          phase_next = PH_Z3E;
        end else begin
          stop = 1'b1; stop_err = ERR_ZONE;
        end
      end
      PH_Z4B, PH_Z5E: begin
        stop = 1'b1;
        if (!isnum) stop_err = ERR_ZONE;
      end
      PH_Z3E: begin
        if (cur != CH_COLON) begin
          stop = 1'b1; stop_err = ERR_ZONE;
        end else begin
          phase_next = PH_Z4E;
        end
      end
      default: begin
        stop = 1'b1; stop_err = ERR_ZONE;
      end
    endcase
  end

  always_comb begin
    cent = 7'(yd0) * 7'd10 + 7'(yd1);
    yrem = 7'(yd2) * 7'd10 + 7'(yd3);
    yc_n = cent + 7'd4;
    yr_n = yrem;
    // january and february count with the previous year
    if (month <= 4'd2) begin
      if (yrem == 7'd0) begin
        yc_n = cent + 7'd3;
        yr_n = 7'd99;
      end else begin
        yr_n = yrem - 7'd1;
      end
    end
  end

  assign tick_sum = (63'(prod_hi) <<< 20) + 63'(prod_lo);
  assign load     = (state == S_FINISH) && (!result_v || result_ready);

  always_ff @(posedge clk) begin
    if (pop && pop_data.keep) begin
      store[length[AW-1:0]] <= pop_data.text_char;
    end
    rd_byte <= store[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_COLLECT;
      phase    <= PH_Y0;
      length   <= '0;
      rd_addr  <= '0;
      rd_pos   <= '0;
      rd_vld   <= 1'b0;
      mode     <= 1'b0;
      err      <= ERR_NONE;
      result_v <= 1'b0;
    end else begin
      if (load) begin
        result_v <= 1'b1;
      end else if (result_ready) begin
        result_v <= 1'b0;
      end
      unique case (state)
        S_COLLECT: begin
          if (pop) begin
            if (pop_data.keep) length <= length + 1'b1;
            if (pop_data.last_char) state <= S_START;
          end
        end
        S_START: begin
          mode    <= time_only_mode;
          rd_addr <= '0;
          rd_vld  <= 1'b0;
          if (length < (time_only_mode ? LW'(6) : LW'(8))) begin
            err   <= ERR_SHORT;
            state <= S_FINISH;
          end else begin
            phase <= time_only_mode ? PH_H0 : PH_Y0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          rd_addr <= rd_addr + 1'b1;
          rd_pos  <= rd_addr;
          rd_vld  <= 1'b1;
          if (rd_vld) begin
            if (stop) begin
              err   <= stop_err;
              state <= (stop_err == ERR_NONE) ? S_CALC0 : S_FINISH;
            end else begin
              phase <= phase_next;
            end
          end
        end
        S_CALC0: state <= S_CALC1;
        S_CALC1: state <= S_CALC2;
        S_CALC2: state <= S_CALC3;
        S_CALC3: state <= S_FINISH;
        S_FINISH: begin
          if (load) begin
            length <= '0;
            state  <= S_COLLECT;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  // field capture and arithmetic datapath
  always_ff @(posedge clk) begin
    if (state == S_START) begin
      hour   <= '0;
      minute <= '0;
      second <= '0;
    end
    if (state == S_WALK && rd_vld) begin
      case (phase)
        PH_Y0:   yd0 <= dig;
        PH_Y1:   yd1 <= dig;
        PH_Y2:   yd2 <= dig;
        PH_Y3:   yd3 <= dig;
        PH_MO0S: begin
          date_ext <= cur == CH_DASH;
          tens     <= dig;
        end
        PH_MI0S: begin
          time_ext <= cur == CH_COLON;
          tens     <= dig;
        end
        PH_MO0D, PH_DA0S, PH_DA0D, PH_H0, PH_MI0D, PH_SE0S, PH_SE0D: tens <= dig;
        PH_MO1:  month  <= pair_val[3:0];
        PH_DA1:  day    <= pair_val[4:0];
        PH_H1:   hour   <= pair_val[4:0];
        PH_MI1:  minute <= pair_val[5:0];
        PH_SE1:  second <= pair_val;
        default: tens <= tens;
      endcase
    end
    if (state == S_CALC0) begin
      yy   <= 14'(yc_n) * 14'd100 + 14'(yr_n);
      misc <= 12'(yc_n) * 12'd24 + 12'(yr_n[6:2]) + 12'(yc_n[6:2])
              + 12'(month_offset(month)) + 12'(day) - 12'd1;
      secs <= 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
    end
    if (state == S_CALC1) begin
      days <= mode ? 24'sd0 :
              $signed(24'(yy) * 24'd365 + 24'(misc)) - 24'sd146403;
    end
    if (state == S_CALC2) begin
      tsec <= 41'(days) * 41'sd86400 + $signed({24'd0, secs});
    end
    if (state == S_CALC3) begin
      prod_lo <= 44'(tsec[19:0]) * 44'd10000000;
      prod_hi <= 45'($signed(tsec[40:20])) * 45'sd10000000;
    end
    if (load) begin
      result_q.tick_count <= (err == ERR_NONE) ? tick_sum : 63'sd0;
      result_q.parse_ok   <= err == ERR_NONE;
      result_q.error_code <= err;
    end
  end

  assign result_valid = result_v;
  assign result_data  = result_q;

  `CHK(a_len_bound, length <= LW'(MAX_CHARS))
  `CHK(a_ok_no_code, result_v |-> (result_q.parse_ok == (result_q.error_code == ERR_NONE)))
  `CHK(a_reject_zero, (result_v && !result_q.parse_ok) |-> (result_q.tick_count == 63'sd0))
endmodule

FILE: rtl/core/iso8601_datetime_parser_top.sv
// ----------------------------------------------------------------------------
// iso8601_datetime_parser_top
// ISO 8601 date/time string parser giving 100 ns ticks since 0001-01-01.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle, while the queue is not full, into a
// four-entry queue. The back end pulls one byte per cycle from the queue,
// while it is not empty, into its byte store (one write port, one read port)
// until the last byte of a string. It then starts in S_START, primes the
// store read, reads the stored string back one byte per cycle, steps through
// the arithmetic states S_CALC0 to S_CALC3 for the day count and tick
// arithmetic and loads the result in S_FINISH. A rejected string skips the
// arithmetic. The front keeps taking bytes until the queue fills. A finished
// result waits in the output register while the next string is collected.
// Bytes beyond MAX_CHARS are neither counted nor stored. No clearing pass is
// needed after reset.
module iso8601_datetime_parser_top import isodt_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         text_valid,
  output logic         text_ready,
  input  text_item_t   text_data,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);
  logic         time_only_mode;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  queue_entry_t push_data;
  queue_entry_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_only_mode <= 1'b0;
    end else if (cfg_valid) begin
      time_only_mode <= cfg_data;
    end
  end

  isodt_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_data  (text_data),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  isodt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  isodt_back #(.MAX_CHARS(MAX_CHARS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_data       (pop_data),
    .empty          (empty),
    .pop            (pop),
    .time_only_mode (time_only_mode),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_data    (result_data)
  );
endmodule
